FILE: rtl/core/okvm_pkg.sv
// ----------------------------------------------------------------------------
// okvm_pkg
// Shared types and constants of the ordered key/value map.
// ----------------------------------------------------------------------------
package okvm_pkg;

    localparam int DATA_W       = 32;
    localparam int COUNT_W      = 7;
    localparam int CAPACITY_DEF = 64;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_FIND   = 2'd1;
    localparam logic [1:0] REQ_LOWER  = 2'd2;
    localparam logic [1:0] REQ_LIST   = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } t_entry;

endpackage

FILE: rtl/core/ordered_key_value_map.sv
// ----------------------------------------------------------------------------
// ordered_key_value_map
// Bounded ordered map of signed 32-bit keys to 32-bit values.
// ----------------------------------------------------------------------------
// A request is given by raising i_start with i_req_type, i_key_in and
// i_value_in; it is taken at a clock edge where o_busy is low. Requests are
// insert, find, lower bound and list. Each result word appears for exactly
// one cycle with o_valid high, and o_last marks the final word of a request.
// Results cannot be held off by the receiver.
// The pairs live in one memory sorted by key, and every request walks it one
// entry per cycle through the single read port. An insert of a new key scans
// up to its position and then moves the higher entries up one at a time. A
// list emits one word per cycle from the registered read port. The next
// request may be given in the cycle where the last result is shown.
// Synchronous reset empties the map; the memory itself is not cleared.
// ----------------------------------------------------------------------------
module ordered_key_value_map
    import okvm_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic [1:0]               i_req_type,
    input  logic signed [DATA_W-1:0] i_key_in,
    input  logic signed [DATA_W-1:0] i_value_in,
    output logic                     o_valid,
    output logic                     o_found,
    output logic signed [DATA_W-1:0] o_key_out,
    output logic signed [DATA_W-1:0] o_value_out,
    output logic [COUNT_W-1:0]       o_entry_count,
    output logic                     o_table_full,
    output logic                     o_last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_PLACE = 3'd3;
    localparam logic [2:0] S_LIST  = 3'd4;

    logic [2:0]               r_state, n_state;
    logic [1:0]               r_req, n_req;
    logic signed [DATA_W-1:0] r_key, n_key;
    logic signed [DATA_W-1:0] r_val, n_val;
    logic [AW-1:0]            r_idx, n_idx;
    logic [CW-1:0]            r_pos, n_pos;
    logic [CW-1:0]            r_count, n_count;

    logic                     r_o_valid, n_o_valid;
    logic                     r_o_found, n_o_found;
    logic signed [DATA_W-1:0] r_o_key, n_o_key;
    logic signed [DATA_W-1:0] r_o_val, n_o_val;
    logic [CW-1:0]            r_o_count, n_o_count;
    logic                     r_o_full, n_o_full;
    logic                     r_o_last, n_o_last;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_rdata;

    logic          at_end;
    logic          key_ge;
    logic          key_eq;
    logic          scan_done;
    logic [CW-1:0] scan_pos;

    okvm_mem #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign at_end    = (CW'(r_idx) + CW'(1)) == r_count;
    assign key_ge    = (r_count != '0) && (mem_rdata.key >= r_key);
    assign key_eq    = key_ge && (mem_rdata.key == r_key);
    assign scan_done = (r_count == '0) || key_ge || at_end;
    assign scan_pos  = key_ge ? CW'(r_idx) : r_count;

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_key     = r_key;
        n_val     = r_val;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_count   = r_count;
        n_o_valid = 1'b0;
        n_o_found = r_o_found;
        n_o_key   = r_o_key;
        n_o_val   = r_o_val;
        n_o_count = r_o_count;
        n_o_full  = r_o_full;
        n_o_last  = r_o_last;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = mem_rdata;
        mem_raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req   = i_req_type;
                    n_key   = i_key_in;
                    n_val   = i_value_in;
                    n_idx   = '0;
                    n_state = (i_req_type == REQ_LIST) ? S_LIST : S_SCAN;
                end
            end
            S_SCAN: begin
                if (!scan_done) begin
                    mem_raddr = r_idx + AW'(1);
                    n_idx     = r_idx + AW'(1);
                end else begin
                    n_state   = S_IDLE;
                    n_o_valid = 1'b1;
                    n_o_last  = 1'b1;
                    n_o_full  = 1'b0;
                    n_o_count = r_count;
                    n_o_found = 1'b0;
                    n_o_key   = '0;
                    n_o_val   = '0;
                    case (r_req)
                        REQ_FIND, REQ_LOWER: begin
                            if (key_eq || (key_ge && r_req == REQ_LOWER)) begin
                                n_o_found = 1'b1;
                                n_o_key   = mem_rdata.key;
                                n_o_val   = mem_rdata.value;
                            end
                        end
                        REQ_INSERT: begin
                            if (key_eq) begin
                                mem_we          = 1'b1;
                                mem_waddr       = r_idx;
                                mem_wdata.key   = r_key;
                                mem_wdata.value = r_val;
                                n_o_found       = 1'b1;
                                n_o_key         = r_key;
                                n_o_val         = r_val;
                            end else if (r_count == CW'(CAPACITY)) begin
                                n_o_full = 1'b1;
                            end else if (scan_pos == r_count) begin
                                mem_we          = 1'b1;
                                mem_waddr       = scan_pos[AW-1:0];
                                mem_wdata.key   = r_key;
                                mem_wdata.value = r_val;
                                n_count         = r_count + CW'(1);
                                n_o_count       = r_count + CW'(1);
                                n_o_found       = 1'b1;
                                n_o_key         = r_key;
                                n_o_val         = r_val;
                            end else begin
                                n_o_valid = 1'b0;
                                n_pos     = scan_pos;
                                mem_raddr = AW'(r_count - CW'(1));
                                n_idx     = r_count[AW-1:0];
                                n_state   = S_SHIFT;
                            end
                        end
                        default: begin
                            n_o_valid = 1'b0;
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = mem_rdata;
                if ((CW'(r_idx) - CW'(1)) == r_pos) begin
                    n_state = S_PLACE;
                end else begin
                    mem_raddr = AW'(CW'(r_idx) - CW'(2));
                    n_idx     = r_idx - AW'(1);
                end
            end
            S_PLACE: begin
                mem_we          = 1'b1;
                mem_waddr       = r_pos[AW-1:0];
                mem_wdata.key   = r_key;
                mem_wdata.value = r_val;
                n_count         = r_count + CW'(1);
                n_state         = S_IDLE;
                n_o_valid       = 1'b1;
                n_o_found       = 1'b1;
                n_o_key         = r_key;
                n_o_val         = r_val;
                n_o_count       = r_count + CW'(1);
                n_o_full        = 1'b0;
                n_o_last        = 1'b1;
            end
            S_LIST: begin
                n_o_valid = 1'b1;
                n_o_full  = 1'b0;
                n_o_count = r_count;
                if (r_count == '0) begin
                    n_o_found = 1'b0;
                    n_o_key   = '0;
                    n_o_val   = '0;
                    n_o_last  = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_o_found = 1'b1;
                    n_o_key   = mem_rdata.key;
                    n_o_val   = mem_rdata.value;
                    n_o_last  = at_end;
                    if (at_end) begin
                        n_state = S_IDLE;
                    end else begin
                        mem_raddr = r_idx + AW'(1);
                        n_idx     = r_idx + AW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
        r_req     <= n_req;
        r_key     <= n_key;
        r_val     <= n_val;
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_o_found <= n_o_found;
        r_o_key   <= n_o_key;
        r_o_val   <= n_o_val;
        r_o_count <= n_o_count;
        r_o_full  <= n_o_full;
        r_o_last  <= n_o_last;
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_found       = r_o_found;
    assign o_key_out     = r_o_key;
    assign o_value_out   = r_o_val;
    assign o_entry_count = COUNT_W'(r_o_count);
    assign o_table_full  = r_o_full;
    assign o_last        = r_o_last;

`ifndef SYNTHESIS
    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_full) |-> (!r_o_found && r_o_count == CW'(CAPACITY)))
        else $error("rejected insert reported with a free entry or a pair");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count))
        |-> (r_count == $past(r_count) + CW'(1)))
        else $error("entry count changed by other than one insert");

    a_shift_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (mem_raddr != mem_waddr))
        else $error("shift reads the entry it writes");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted request did not make the block busy");
`endif

endmodule

FILE: rtl/core/okvm_mem.sv
// ----------------------------------------------------------------------------
// okvm_mem
// Sorted pair storage: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module okvm_mem
    import okvm_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int AW       = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [CAPACITY];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
